// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL; reset disables each check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds in the same cycle as cond.
`define ASSERT_IMPLIES(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("same-cycle implication failed");

// Check that prop holds in the cycle after cond.
`define ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/apsp_pkg.sv =====
// ----------------------------------------------------------------------------
// apsp_pkg
// Field widths and request, register and result codes of the path engine.
// ----------------------------------------------------------------------------
`default_nettype none

package apsp_pkg;

    localparam int MODE_W     = 2;
    localparam int IDX_W      = 8;
    localparam int LEN_W      = 16;
    localparam int OUT_W      = 16;
    localparam int NC_W       = 9;
    localparam int NP_W       = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_WRITE = 2'd0;
    localparam t_mode MODE_RUN   = 2'd1;
    localparam t_mode MODE_READ  = 2'd2;
    localparam t_mode MODE_CLEAR = 2'd3;

    localparam t_cfg_idx CFG_NODE_COUNT = 1'd0;
    localparam t_cfg_idx CFG_NO_PATH    = 1'd1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/apsp_if.sv =====
// ----------------------------------------------------------------------------
// apsp interfaces
// Request, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface apsp_in_if import apsp_pkg::*; ();
    logic              valid;
    logic              ready;
    t_mode             mode;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [LEN_W-1:0]  length;

    modport source (output valid, output mode, output row, output col, output length,
                    input ready);
    modport sink   (input valid, input mode, input row, input col, input length,
                    output ready);
endinterface

interface apsp_out_if import apsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  distance;
    logic              kind;

    modport source (output valid, output distance, output kind, input ready);
    modport sink   (input valid, input distance, input kind, output ready);
endinterface

interface apsp_cfg_if import apsp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/apsp_dist_mem.sv =====
// ----------------------------------------------------------------------------
// apsp_dist_mem
// Distance matrix store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module apsp_dist_mem #(
    parameter int ADDR_BITS = 16,
    parameter int DATA_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [DATA_BITS-1:0] i_wdata,
    input  wire logic                 i_re_a,
    input  wire logic [ADDR_BITS-1:0] i_raddr_a,
    output logic      [DATA_BITS-1:0] o_rdata_a,
    input  wire logic                 i_re_b,
    input  wire logic [ADDR_BITS-1:0] i_raddr_b,
    output logic      [DATA_BITS-1:0] o_rdata_b
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] r_mem [0:DEPTH-1];
    logic [DATA_BITS-1:0] r_qa;
    logic [DATA_BITS-1:0] r_qb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read on the same port.
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_qa <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_qb <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_qa;
    assign o_rdata_b = r_qb;

endmodule

`default_nettype wire

// ===== hw/rtl/apsp_relax.sv =====
// ----------------------------------------------------------------------------
// apsp_relax
// Min-plus relaxation of one entry with a saturating path sum.
// ----------------------------------------------------------------------------
`default_nettype none

module apsp_relax #(
    parameter int DIST_BITS = 16
) (
    input  wire logic [DIST_BITS-1:0] i_dik,
    input  wire logic [DIST_BITS-1:0] i_dkj,
    input  wire logic [DIST_BITS-1:0] i_dij,
    input  wire logic [DIST_BITS-1:0] i_inf,
    output logic                      o_upd,
    output logic      [DIST_BITS-1:0] o_dist
);

    logic [DIST_BITS:0]   w_sum;
    logic [DIST_BITS-1:0] w_sat;

    assign w_sum  = {1'b0, i_dik} + {1'b0, i_dkj};
    // Clamp the sum to the no-path value.
    assign w_sat  = (w_sum > {1'b0, i_inf}) ? i_inf : w_sum[DIST_BITS-1:0];
    // Drop legs that are unreachable.
    assign o_upd  = (i_dkj < i_inf) && (w_sat < i_dij);
    assign o_dist = w_sat;

endmodule

`default_nettype wire

// ===== hw/rtl/all_pairs_shortest_path_top.sv =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_top
// Distance matrix engine with Floyd-Warshall closure over a single RAM.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries requests: write one entry, run closure, read one entry or
//   clear the matrix. o_rsp returns one result for a read (kind 0) and one
//   for a finished closure (kind 1, distance 0). i_cfg writes node_count
//   (index 0) and no_path_value (index 1); it is always ready, and the user
//   must write it only while the engine is idle; the block does not enforce it.
//   A write completes in idle, so writes stream one per cycle. A read loads
//   the entry into the RAM read register, then into the result register once
//   that register is free. A clear sweeps every RAM word, 4**clog2(MAX_NODES)
//   words (65536 by default). A closure over n nodes fetches d[i][k] for each
//   (k, i) pair and, for each pair whose d[i][k] is reachable, streams row k
//   one entry per cycle through the relaxation and writes back improvements.
//   Reset leaves the matrix contents undefined until cleared or written and
//   restores the register defaults (256 nodes, no-path 65535).
//   The result register decouples the result side: a further request is
//   taken while a result waits; a read or run that finishes while the
//   receiver stalls holds in its final state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module all_pairs_shortest_path_top import apsp_pkg::*; #(
    parameter int MAX_NODES = 256,
    parameter int DIST_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    apsp_in_if.sink    i_req,
    apsp_out_if.source o_rsp,
    apsp_cfg_if.sink   i_cfg
);

    // Index widths and extension widths for the fixed-size port fields.
    localparam int NB  = $clog2(MAX_NODES);
    localparam int AW  = 2 * NB;
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int NCW = (CW > NC_W) ? CW : NC_W;
    localparam int RW  = (CW > IDX_W) ? CW : IDX_W;
    localparam int LW  = (DIST_BITS > LEN_W) ? DIST_BITS : LEN_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_IK    = 3'd3;
    localparam logic [2:0] S_IKW   = 3'd4;
    localparam logic [2:0] S_ROW   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Control registers.
    logic [2:0]      r_state, n_state;
    logic            r_p1_valid;
    logic            r_out_valid;
    logic [NC_W-1:0] r_node_count;
    logic [NP_W-1:0] r_no_path;

    // Sequencer and payload registers.
    logic [NB-1:0]        r_i, r_j, r_k, r_last;
    logic [NB-1:0]        r_p1_i, r_p1_j;
    logic [AW-1:0]        r_clr;
    logic [DIST_BITS-1:0] r_dik;
    logic                 r_rd_oor;
    logic [OUT_W-1:0]     r_out_dist;
    logic                 r_out_kind;

    // RAM ports.
    logic                 w_we, w_re_a, w_re_b;
    logic [AW-1:0]        w_waddr, w_addr_a, w_addr_b;
    logic [DIST_BITS-1:0] w_wdata, w_qa, w_qb;

    // Request decode and derived values.
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_out_load;
    logic [OUT_W-1:0]     w_out_dist;
    logic                 w_out_kind;
    logic [RW-1:0]        w_row_ext, w_col_ext;
    logic                 w_inside;
    logic [NB-1:0]        w_row_idx, w_col_idx;
    logic [LW-1:0]        w_np_ext, w_dmax_ext, w_inf_ext, w_len_ext, w_rd_ext;
    logic [DIST_BITS-1:0] w_inf, w_len, w_wr_val, w_rd_val;
    logic [NCW-1:0]       w_nc_ext, w_n, w_n_m1;
    logic [2:0]           w_adv_state;
    logic                 w_upd;
    logic [DIST_BITS-1:0] w_relax_dist;

    apsp_dist_mem #(
        .ADDR_BITS (AW),
        .DATA_BITS (DIST_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re_a    (w_re_a),
        .i_raddr_a (w_addr_a),
        .o_rdata_a (w_qa),
        .i_re_b    (w_re_b),
        .i_raddr_b (w_addr_b),
        .o_rdata_b (w_qb)
    );

    // Port A carries d[k][j], port B carries d[i][j] in the row stage.
    apsp_relax #(
        .DIST_BITS (DIST_BITS)
    ) u_relax (
        .i_dik  (r_dik),
        .i_dkj  (w_qa),
        .i_dij  (w_qb),
        .i_inf  (w_inf),
        .o_upd  (w_upd),
        .o_dist (w_relax_dist)
    );

    // Handshakes: requests only in idle, register writes at any time.
    assign i_req.ready    = (r_state == S_IDLE);
    assign w_in_acc       = i_req.valid && (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.distance = r_out_dist;
    assign o_rsp.kind     = r_out_kind;
    assign w_out_free     = !r_out_valid || o_rsp.ready;

    // Effective no-path value: the register capped at the widest distance.
    assign w_np_ext   = LW'(r_no_path);
    assign w_dmax_ext = LW'({DIST_BITS{1'b1}});
    assign w_inf_ext  = (w_np_ext < w_dmax_ext) ? w_np_ext : w_dmax_ext;
    assign w_inf      = w_inf_ext[DIST_BITS-1:0];

    // Range check and indices of a write or read request.
    assign w_row_ext = RW'(i_req.row);
    assign w_col_ext = RW'(i_req.col);
    assign w_inside  = (w_row_ext < RW'(MAX_NODES)) && (w_col_ext < RW'(MAX_NODES));
    assign w_row_idx = w_row_ext[NB-1:0];
    assign w_col_idx = w_col_ext[NB-1:0];

    // Cut the written length to the distance width, then clamp at no-path.
    assign w_len_ext = LW'(i_req.length);
    assign w_len     = w_len_ext[DIST_BITS-1:0];
    assign w_wr_val  = (w_len > w_inf) ? w_inf : w_len;

    // Out-of-range reads answer no-path; keep the low bits of the entry.
    assign w_rd_val  = r_rd_oor ? w_inf : w_qa;
    assign w_rd_ext  = LW'(w_rd_val);

    // Node count, capped at the matrix size.
    assign w_nc_ext = NCW'(r_node_count);
    assign w_n      = (w_nc_ext > NCW'(MAX_NODES)) ? NCW'(MAX_NODES) : w_nc_ext;
    assign w_n_m1   = w_n - NCW'(1);

    // Where the sequencer goes after finishing row i of pass k.
    assign w_adv_state = ((r_i == r_last) && (r_k == r_last)) ? S_DONE : S_IK;

    always_comb begin
        n_state    = r_state;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = '0;
        w_re_a     = 1'b0;
        w_addr_a   = '0;
        w_re_b     = 1'b0;
        w_addr_b   = '0;
        w_out_load = 1'b0;
        w_out_dist = '0;
        w_out_kind = KIND_READ;

        // Write back an improved entry from the row stage.
        if (r_p1_valid && w_upd) begin
            w_we    = 1'b1;
            w_waddr = {r_p1_i, r_p1_j};
            w_wdata = w_relax_dist;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_req.mode)
                        MODE_WRITE: begin
                            w_we    = w_inside;
                            w_waddr = {w_row_idx, w_col_idx};
                            w_wdata = w_wr_val;
                        end
                        MODE_RUN: begin
                            n_state = (w_n == '0) ? S_DONE : S_IK;
                        end
                        MODE_READ: begin
                            w_re_a   = w_inside;
                            w_addr_a = {w_row_idx, w_col_idx};
                            n_state  = S_READ;
                        end
                        MODE_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                    endcase
                end
            end
            S_READ: begin
                // Hold the read data on port A until the result register frees.
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_dist = w_rd_ext[OUT_W-1:0];
                    w_out_kind = KIND_READ;
                    n_state    = S_IDLE;
                end
            end
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = (r_clr[AW-1:NB] == r_clr[NB-1:0]) ? '0 : w_inf;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IK: begin
                w_re_a   = 1'b1;
                w_addr_a = {r_i, r_k};
                n_state  = S_IKW;
            end
            S_IKW: begin
                // Skip the row when d[i][k] is unreachable.
                n_state = (w_qa >= w_inf) ? w_adv_state : S_ROW;
            end
            S_ROW: begin
                w_re_a   = 1'b1;
                w_addr_a = {r_k, r_j};
                w_re_b   = 1'b1;
                w_addr_b = {r_i, r_j};
                if (r_j == r_last) begin
                    n_state = w_adv_state;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_dist = '0;
                    w_out_kind = KIND_DONE;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_p1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_node_count <= NC_W'(256);
            r_no_path    <= NP_W'(65535);
        end else begin
            r_state    <= n_state;
            r_p1_valid <= (r_state == S_ROW);
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_NODE_COUNT: r_node_count <= i_cfg.data[NC_W-1:0];
                    CFG_NO_PATH:    r_no_path    <= i_cfg.data[NP_W-1:0];
                endcase
            end
        end
    end

    // Loop counters and payload.
    always_ff @(posedge i_clk) begin
        r_p1_i <= r_i;
        r_p1_j <= r_j;
        if (w_out_load) begin
            r_out_dist <= w_out_dist;
            r_out_kind <= w_out_kind;
        end
        case (r_state)
            S_IDLE: begin
                r_i      <= '0;
                r_k      <= '0;
                r_clr    <= '0;
                r_last   <= w_n_m1[NB-1:0];
                r_rd_oor <= !w_inside;
            end
            S_CLEAR: begin
                r_clr <= r_clr + AW'(1);
            end
            S_IKW: begin
                r_dik <= w_qa;
                r_j   <= '0;
                if (w_qa >= w_inf) begin
                    if (r_i == r_last) begin
                        r_i <= '0;
                        r_k <= r_k + NB'(1);
                    end else begin
                        r_i <= r_i + NB'(1);
                    end
                end
            end
            S_ROW: begin
                if (r_j == r_last) begin
                    if (r_i == r_last) begin
                        r_i <= '0;
                        r_k <= r_k + NB'(1);
                    end else begin
                        r_i <= r_i + NB'(1);
                    end
                end else begin
                    r_j <= r_j + NB'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Row stream stays inside the active node range.
    `ASSERT_IMPLIES(a_loop_bounds, i_clk, i_rst_n, r_state == S_ROW,
                    (r_j <= r_last) && (r_i <= r_last) && (r_k <= r_last))
    // Write-back only follows a row cycle, never a clear or idle write.
    `ASSERT_IMPLIES(a_wb_phase, i_clk, i_rst_n, r_p1_valid,
                    (r_state == S_ROW) || (r_state == S_IK) || (r_state == S_DONE))
    // Finishing a closure leaves a done result and an idle engine.
    `ASSERT_NEXT(a_done_result, i_clk, i_rst_n, (r_state == S_DONE) && w_out_load,
                 r_out_valid && (r_out_kind == KIND_DONE) && (r_state == S_IDLE))

endmodule

`default_nettype wire

// ===== tb/apsp_path_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_path_checker
// Watches the request, result and register channels of the path engine,
// keeps its own copy of the distance matrix and checks every result in order.
// ----------------------------------------------------------------------------

module apsp_path_checker import apsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    apsp_in_if   i_req,
    apsp_out_if  i_rsp,
    apsp_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int NODES  = 256;
    localparam int DIST_W = 16;

    typedef struct packed {
        logic [OUT_W-1:0] distance;
        logic             kind;
    } t_answer;

    // DIST_BITS matches the no-path register width, so no cap applies here.
    bit [DIST_W-1:0] dist_tab [NODES][NODES];
    logic [NC_W-1:0] node_cnt;
    logic [NP_W-1:0] no_path;
    t_answer         pending_answers [$];
    int              fails;

    function automatic void wipe_matrix();
        for (int r = 0; r < NODES; r++)
            for (int c = 0; c < NODES; c++)
                dist_tab[r][c] = (r == c) ? '0 : no_path;
    endfunction

    // Min-plus closure over the active nodes; legs at or above no-path are skipped.
    function automatic void close_paths();
        int unsigned     n;
        bit [DIST_W-1:0] dik;
        bit [DIST_W-1:0] dkj;
        bit [DIST_W:0]   sum;
        n = (node_cnt > NODES) ? NODES : node_cnt;
        for (int unsigned k = 0; k < n; k++) begin
            for (int unsigned i = 0; i < n; i++) begin
                dik = dist_tab[i][k];
                if (dik >= no_path)
                    continue;
                for (int unsigned j = 0; j < n; j++) begin
                    dkj = dist_tab[k][j];
                    if (dkj >= no_path)
                        continue;
                    sum = dik + dkj;
                    if (sum > no_path)
                        sum = no_path;
                    if (sum < dist_tab[i][j])
                        dist_tab[i][j] = sum[DIST_W-1:0];
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            node_cnt = 9'd256;
            no_path  = 16'hFFFF;
            pending_answers.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_NODE_COUNT: node_cnt = i_cfg.data[NC_W-1:0];
                    CFG_NO_PATH:    no_path  = i_cfg.data[NP_W-1:0];
                    default: ;
                endcase
            end

            // Results come from older requests, so retire before predicting.
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_answers.size() == 0) begin
                    $error("result with nothing outstanding: distance %0d kind %0d",
                           i_rsp.distance, i_rsp.kind);
                    fails++;
                end else begin
                    want = pending_answers.pop_front();
                    if (i_rsp.distance !== want.distance) begin
                        $error("distance: expected %0d, got %0d", want.distance,
                               i_rsp.distance);
                        fails++;
                    end
                    if (i_rsp.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, i_rsp.kind);
                        fails++;
                    end
                end
            end

            if (i_req.valid && i_req.ready) begin
                case (i_req.mode)
                    MODE_WRITE:
                        dist_tab[i_req.row][i_req.col] =
                            (i_req.length > no_path) ? no_path : i_req.length;
                    MODE_RUN: begin
                        close_paths();
                        want.distance = '0;
                        want.kind     = KIND_DONE;
                        pending_answers = {pending_answers, want};
                    end
                    MODE_READ: begin
                        want.distance = dist_tab[i_req.row][i_req.col];
                        want.kind     = KIND_READ;
                        pending_answers = {pending_answers, want};
                    end
                    MODE_CLEAR:
                        wipe_matrix();
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_answers.size();
    end

endmodule

// ===== tb/all_pairs_shortest_path_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_top_tb
// Drives loads, closures, reads and clears into the path engine under random
// back-pressure; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------

module all_pairs_shortest_path_top_tb import apsp_pkg::*; ();

    // Cycles to hold after the last result before touching registers or ending.
    localparam int SETTLE_CYCLES = 16;
    // Requests per random phase, and number of phases.
    localparam int PHASE_ITEMS   = 200;
    localparam int PHASES        = 6;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic calm    = 1'b0;

    int          fail_count;
    int          pending;
    int unsigned items_sent = 0;
    int unsigned rsp_stall  = 0;

    apsp_in_if  req ();
    apsp_out_if rsp ();
    apsp_cfg_if cfg ();

    all_pairs_shortest_path_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .i_cfg   (cfg)
    );

    apsp_path_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_rsp        (rsp),
        .i_cfg        (cfg),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop: a closure over all 256 nodes plus the clears and the random
    // traffic stay well inside a tenth of this.
    initial begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 80)
            return $urandom_range(1, 3);
        else if (p < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Flip between stretches with idling and stretches without.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 399) == 0)
            calm <= ~calm;
    end

    // Result side back-pressure: hold ready low for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (rsp_stall != 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= gap_len() - 1;
            rsp.ready <= 1'b0;
        end else begin
            rsp.ready <= 1'b1;
        end
    end

    // Offer one request, perhaps after an idle gap, and hold it until taken.
    // Valid stays high afterwards so back-to-back requests stream.
    task automatic send(t_mode mode, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                        logic [LEN_W-1:0] length);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
        req.valid  <= 1'b1;
        req.mode   <= mode;
        req.row    <= row;
        req.col    <= col;
        req.length <= length;
        do @(posedge i_clk); while (!req.ready);
        items_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the engine settle.
    task automatic settle();
        req.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; valid is left high so a second write follows directly.
    task automatic cfg_write(t_cfg_idx index, logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
    endtask

    // Write both registers; only called while the engine is idle.
    task automatic set_regs(logic [CFG_DATA_W-1:0] nc_word, logic [CFG_DATA_W-1:0] np_word);
        cfg_write(CFG_NODE_COUNT, nc_word);
        cfg_write(CFG_NO_PATH, np_word);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [IDX_W-1:0] pick_node(int unsigned span);
        return IDX_W'($urandom_range(0, span - 1));
    endfunction

    // Edge lengths: mostly short so paths chain, some near or past no-path.
    function automatic logic [LEN_W-1:0] pick_length(logic [NP_W-1:0] np);
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return LEN_W'($urandom());
        if (p < 25)
            return LEN_W'($urandom_range(np / 2, np));
        return LEN_W'($urandom_range(0, (np < 64) ? np : np / 4));
    endfunction

    // A well-formed sequence: load edges among the active nodes, close, read back.
    task automatic graph_burst(int unsigned n, logic [NP_W-1:0] np);
        int unsigned span;
        span = (n == 0) ? 4 : n;
        repeat ($urandom_range(1, 2 * span))
            send(MODE_WRITE, pick_node(span), pick_node(span), pick_length(np));
        if ($urandom_range(0, 4) != 0)
            send(MODE_RUN, IDX_W'($urandom()), IDX_W'($urandom()), LEN_W'($urandom()));
        repeat ($urandom_range(1, span + 2))
            send(MODE_READ, pick_node(span), pick_node(span), LEN_W'($urandom()));
    endtask

    // Noise: writes and reads anywhere in the matrix, the odd closure.
    task automatic noise_item();
        int unsigned p;
        p = $urandom_range(0, 19);
        if (p < 9)
            send(MODE_WRITE, IDX_W'($urandom()), IDX_W'($urandom()), LEN_W'($urandom()));
        else if (p < 19)
            send(MODE_READ, IDX_W'($urandom()), IDX_W'($urandom()), LEN_W'($urandom()));
        else
            send(MODE_RUN, IDX_W'($urandom()), IDX_W'($urandom()), LEN_W'($urandom()));
    endtask

    initial begin
        logic [NC_W-1:0] nc;
        logic [NP_W-1:0] np;
        int unsigned     phase_end;

        // Every input known from time zero.
        req.valid  = 1'b0;
        req.mode   = MODE_WRITE;
        req.row    = '0;
        req.col    = '0;
        req.length = '0;
        cfg.valid  = 1'b0;
        cfg.index  = CFG_NODE_COUNT;
        cfg.data   = '0;
        rsp.ready  = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Node count field all ones acts as the full 256 nodes; no-path at
        // its maximum. Clear first so nothing is read before it is defined.
        set_regs(16'hFFFF, 16'hFFFF);
        send(MODE_CLEAR, 8'd0, 8'd0, 16'd0);
        send(MODE_WRITE, 8'd0, 8'd1, 16'd3);
        send(MODE_WRITE, 8'd1, 8'd2, 16'd4);
        send(MODE_WRITE, 8'd255, 8'd0, 16'hFFFF);
        send(MODE_WRITE, 8'd255, 8'd254, 16'd0);
        send(MODE_RUN, 8'd0, 8'd0, 16'd0);
        send(MODE_READ, 8'd0, 8'd2, 16'd0);
        send(MODE_READ, 8'd255, 8'd0, 16'd0);
        send(MODE_READ, 8'd255, 8'd254, 16'd0);
        settle();

        // Small no-path: old cleared entries now count as unreachable, sums
        // saturate, and an over-long edge is stored as no-path.
        set_regs(16'd4, 16'd100);
        send(MODE_WRITE, 8'd0, 8'd1, 16'd60);
        send(MODE_WRITE, 8'd1, 8'd2, 16'd60);
        send(MODE_WRITE, 8'd2, 8'd3, 16'hFFFF);
        send(MODE_WRITE, 8'd3, 8'd0, 16'd0);
        send(MODE_RUN, 8'hFF, 8'hFF, 16'hFFFF);
        send(MODE_READ, 8'd0, 8'd2, 16'd0);
        send(MODE_READ, 8'd3, 8'd1, 16'd0);
        send(MODE_READ, 8'd2, 8'd3, 16'd0);
        settle();

        // Zero nodes: closure touches nothing but still reports done.
        set_regs(16'd0, 16'd1);
        send(MODE_WRITE, 8'd1, 8'd0, 16'd5);
        send(MODE_RUN, 8'd0, 8'd0, 16'd0);
        send(MODE_READ, 8'd1, 8'd0, 16'd0);
        settle();

        // Zero no-path, with the upper register bits set above the count:
        // clear fills with zeros and closure leaves everything alone.
        set_regs(16'hFE01, 16'd0);
        send(MODE_CLEAR, 8'd0, 8'd0, 16'd0);
        send(MODE_WRITE, 8'd0, 8'd1, 16'h8000);
        send(MODE_RUN, 8'd0, 8'd0, 16'd0);
        send(MODE_READ, 8'd0, 8'd255, 16'd0);
        settle();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0:       nc = 9'd0;
                1:       nc = 9'd1;
                9:       nc = 9'd12;
                default: nc = NC_W'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 3))
                0:       np = 16'hFFFF;
                1:       np = NP_W'($urandom_range(1, 40));
                2:       np = NP_W'($urandom_range(41, 2000));
                default: np = NP_W'($urandom_range(1, 16'hFFFF));
            endcase
            set_regs({7'($urandom_range(0, 127)), nc}, np);

            // A clear sweeps the whole RAM, so keep them to two phases.
            if (ph == 0 || ph == 3)
                send(MODE_CLEAR, IDX_W'($urandom()), IDX_W'($urandom()), LEN_W'($urandom()));

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) < 7)
                    graph_burst(nc, np);
                else
                    noise_item();
            end
            // Close on a read so its result marks the engine as idle.
            send(MODE_READ, IDX_W'($urandom()), IDX_W'($urandom()), LEN_W'($urandom()));
            settle();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
